### src/afrp_pkg.sv
`default_nettype none
package afrp_pkg;

	localparam logic [7:0]  DELIM        = 8'h7E;
	localparam logic [15:0] HDR_OVERHEAD = 16'd12;

	// APB: register index is paddr[2], one 32-bit register per word
	localparam int unsigned CFG_ADDR_W      = 3;
	localparam logic        CFG_IDX_TIMEOUT = 1'b0;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PAYLOAD   = 2'd0;
	localparam kind_t KIND_COMPLETE  = 2'd1;
	localparam kind_t KIND_TIMEOUT   = 2'd2;
	localparam kind_t KIND_MALFORMED = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [7:0]  api_id;
		logic [31:0] source_addr_high;
		logic [31:0] source_addr_low;
		logic [15:0] net_address;
		logic [7:0]  option_bits;
		logic [7:0]  checksum_byte;
		logic [15:0] payload_length;
	} afrp_result_t;

endpackage
`default_nettype wire

### src/afrp_if.sv
`default_nettype none
interface afrp_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface afrp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [7:0]  api_id;
	logic [31:0] source_addr_high;
	logic [31:0] source_addr_low;
	logic [15:0] net_address;
	logic [7:0]  option_bits;
	logic [7:0]  checksum_byte;
	logic [15:0] payload_length;

	modport source (output valid, output kind, output payload_byte, output payload_index,
		output api_id, output source_addr_high, output source_addr_low,
		output net_address, output option_bits, output checksum_byte,
		output payload_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input payload_index,
		input api_id, input source_addr_high, input source_addr_low,
		input net_address, input option_bits, input checksum_byte,
		input payload_length, output ready);
endinterface
`default_nettype wire

### src/afrp_cfg.sv
`default_nettype none
module afrp_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [afrp_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	output logic      [15:0]                     timeout_ticks
);
	import afrp_pkg::*;

	logic [15:0] timeout_q;
	logic        wr_en;

	assign pready        = 1'b1;
	assign wr_en         = psel && penable && pwrite;
	assign timeout_ticks = timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en && paddr[2] == CFG_IDX_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			CFG_IDX_TIMEOUT: prdata = {16'h0000, timeout_q};
			default:         prdata = 32'h0000_0000;
		endcase
	end
endmodule
`default_nettype wire

### src/afrp_core.sv
`default_nettype none
module afrp_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] timeout_ticks,
	afrp_in_if.sink          in_ch,
	afrp_out_if.source       out_ch
);
	import afrp_pkg::*;

	typedef enum logic [3:0] {
		PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_API, PH_ADDR,
		PH_NET, PH_OPT, PH_DATA, PH_CSUM
	} phase_t;

	// input stage
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	// parser state
	phase_t      phase_q, phase_d;
	logic [15:0] field_q, field_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  api_q, api_d;
	logic [31:0] ahi_q, ahi_d;
	logic [31:0] alo_q, alo_d;
	logic [15:0] net_q, net_d;
	logic [7:0]  opt_q, opt_d;

	// result register
	logic         out_valid_q;
	afrp_result_t res_q, res_d;
	logic         res_vld;

	logic        advance;
	logic        proc;
	logic [16:0] tick_inc;
	logic [15:0] field_inc;
	logic [15:0] pay_len;
	logic [15:0] len_lo;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign proc        = valid_s1 && advance;

	assign tick_inc  = {1'b0, tick_q} + 17'd1;
	assign field_inc = field_q + 16'd1;
	assign pay_len   = len_q - HDR_OVERHEAD;
	assign len_lo    = {len_q[15:8], byte_s1};

	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		tick_d  = tick_q;
		len_d   = len_q;
		api_d   = api_q;
		ahi_d   = ahi_q;
		alo_d   = alo_q;
		net_d   = net_q;
		opt_d   = opt_q;
		res_d   = '0;
		res_vld = 1'b0;

		if (action_s1) begin
			// ticks only count inside a frame
			if (phase_q != PH_HUNT) begin
				if (tick_inc > {1'b0, timeout_ticks}) begin
					phase_d    = PH_HUNT;
					field_d    = '0;
					tick_d     = '0;
					res_d.kind = KIND_TIMEOUT;
					res_vld    = 1'b1;
				end else begin
					tick_d = tick_inc[15:0];
				end
			end
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (byte_s1 == DELIM) begin
						phase_d = PH_LEN_HI;
						field_d = '0;
						tick_d  = '0;
					end
				end
				PH_LEN_HI: begin
					// tick count carries on into the low length byte
					len_d   = {byte_s1, 8'h00};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d   = len_lo;
					field_d = '0;
					tick_d  = '0;
					if (len_lo < HDR_OVERHEAD) begin
						phase_d    = PH_HUNT;
						res_d.kind = KIND_MALFORMED;
						res_vld    = 1'b1;
					end else begin
						phase_d = PH_API;
					end
				end
				PH_API: begin
					api_d   = byte_s1;
					ahi_d   = '0;
					alo_d   = '0;
					phase_d = PH_ADDR;
					field_d = '0;
					tick_d  = '0;
				end
				PH_ADDR: begin
					if (field_q < 16'd4) begin
						ahi_d = {ahi_q[23:0], byte_s1};
					end else begin
						alo_d = {alo_q[23:0], byte_s1};
					end
					field_d = field_inc;
					if (field_inc >= 16'd8) begin
						net_d   = '0;
						phase_d = PH_NET;
						field_d = '0;
						tick_d  = '0;
					end
				end
				PH_NET: begin
					net_d   = {net_q[7:0], byte_s1};
					field_d = field_inc;
					if (field_inc >= 16'd2) begin
						phase_d = PH_OPT;
						field_d = '0;
						tick_d  = '0;
					end
				end
				PH_OPT: begin
					opt_d   = byte_s1;
					phase_d = (len_q > HDR_OVERHEAD) ? PH_DATA : PH_CSUM;
					field_d = '0;
					tick_d  = '0;
				end
				PH_DATA: begin
					res_d.kind          = KIND_PAYLOAD;
					res_d.payload_byte  = byte_s1;
					res_d.payload_index = field_q;
					res_vld             = 1'b1;
					field_d             = field_inc;
					if (field_inc >= pay_len) begin
						phase_d = PH_CSUM;
						field_d = '0;
						tick_d  = '0;
					end
				end
				PH_CSUM: begin
					res_d.kind             = KIND_COMPLETE;
					res_d.api_id           = api_q;
					res_d.source_addr_high = ahi_q;
					res_d.source_addr_low  = alo_q;
					res_d.net_address      = net_q;
					res_d.option_bits      = opt_q;
					res_d.checksum_byte    = byte_s1;
					res_d.payload_length   = pay_len;
					res_vld                = 1'b1;
					phase_d                = PH_HUNT;
					field_d                = '0;
					tick_d                 = '0;
				end
				default: begin
					phase_d = PH_HUNT;
					field_d = '0;
					tick_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			action_s1   <= 1'b0;
			byte_s1     <= '0;
			phase_q     <= PH_HUNT;
			field_q     <= '0;
			tick_q      <= '0;
			len_q       <= '0;
			api_q       <= '0;
			ahi_q       <= '0;
			alo_q       <= '0;
			net_q       <= '0;
			opt_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1  <= in_ch.valid;
				action_s1 <= in_ch.action;
				byte_s1   <= in_ch.rx_byte;
			end
			if (proc) begin
				phase_q     <= phase_d;
				field_q     <= field_d;
				tick_q      <= tick_d;
				len_q       <= len_d;
				api_q       <= api_d;
				ahi_q       <= ahi_d;
				alo_q       <= alo_d;
				net_q       <= net_d;
				opt_q       <= opt_d;
				out_valid_q <= res_vld;
				if (res_vld) begin
					res_q <= res_d;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.kind             = res_q.kind;
	assign out_ch.payload_byte     = res_q.payload_byte;
	assign out_ch.payload_index    = res_q.payload_index;
	assign out_ch.api_id           = res_q.api_id;
	assign out_ch.source_addr_high = res_q.source_addr_high;
	assign out_ch.source_addr_low  = res_q.source_addr_low;
	assign out_ch.net_address      = res_q.net_address;
	assign out_ch.option_bits      = res_q.option_bits;
	assign out_ch.checksum_byte    = res_q.checksum_byte;
	assign out_ch.payload_length   = res_q.payload_length;
endmodule
`default_nettype wire

### src/api_frame_receive_parser.sv
// Byte-serial API receive frame parser. Each input item is a received byte
// (action 0) or a time tick (action 1); bytes are dropped until a 0x7E
// delimiter, then length, API id, 64-bit source address, network address,
// options, payload and checksum are taken in order. Every payload byte gives
// a result with its index, the checksum byte gives a frame-complete result
// with the header fields, a too-short length gives a malformed result and a
// field that sees more than timeout_ticks ticks gives a timeout result. One
// item is accepted per clock while the result side keeps up: an item is
// held in the input register, the combinational phase machine works on it,
// and the result register hands results on. timeout_ticks sits at APB
// address 0x0 and should be written only while the block is idle.
`default_nettype none
module api_frame_receive_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	afrp_in_if.sink                              in_ch,
	afrp_out_if.source                           out_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [afrp_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready
);
	import afrp_pkg::*;

	logic [15:0] timeout_ticks;

	afrp_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	afrp_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_ticks),
		.in_ch         (in_ch),
		.out_ch        (out_ch)
	);
endmodule
`default_nettype wire

### src/afrp_checker.sv
`default_nettype none
module afrp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        pready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  kind,
	input wire logic [7:0]  payload_byte,
	input wire logic [15:0] payload_index,
	input wire logic [7:0]  api_id,
	input wire logic [31:0] source_addr_high,
	input wire logic [15:0] payload_length
);
	import afrp_pkg::*;

	// configuration writes never wait
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_index))
		else $error("stalled result changed");

	// header fields only on frame-complete results
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_COMPLETE |->
		api_id == 8'h00 && source_addr_high == 32'h0 && payload_length == 16'h0)
		else $error("header fields on non-complete result");

	// payload fields only on payload results
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'h00 && payload_index == 16'h0)
		else $error("payload fields on non-payload result");

	// a complete frame never reports more payload than the largest legal length
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_COMPLETE |-> payload_length <= 16'd65523)
		else $error("payload length out of range");
endmodule

bind api_frame_receive_parser afrp_checker u_afrp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.pready           (pready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.kind             (out_ch.kind),
	.payload_byte     (out_ch.payload_byte),
	.payload_index    (out_ch.payload_index),
	.api_id           (out_ch.api_id),
	.source_addr_high (out_ch.source_addr_high),
	.payload_length   (out_ch.payload_length)
);
`default_nettype wire
